// ===== hw/rtl/g2j_pkg.sv =====
// Package for the gamepad to joystick port adapter.
// Holds the transaction types, register and event codes, and the key map tables.
// No dependencies.
package g2j_pkg;

  // Number of key matrix rows and widths of the configuration port.
  localparam int unsigned KEY_ROWS  = 8;
  localparam int unsigned ROW_IDX_W = $clog2(KEY_ROWS);
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 15;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_JOY_TYPE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DPAD_UP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DPAD_RIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DPAD_DOWN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DPAD_LEFT  = 3'd5;

  // Joystick types.
  localparam logic [1:0] JT_BITMASK = 2'd0;
  localparam logic [1:0] JT_KEYS_60 = 2'd1;
  localparam logic [1:0] JT_KEYS_15 = 2'd2;
  localparam logic [1:0] JT_CURSOR  = 2'd3;

  // Event kinds.
  localparam logic [1:0] EV_AXIS   = 2'd0;
  localparam logic [1:0] EV_BUTTON = 2'd1;
  localparam logic [1:0] EV_HAT    = 2'd2;

  // Direction indexes; hat bit i is direction i.
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [14:0] DEADZONE_RST = 15'd8000;
  localparam logic [5:0]  DPAD_NONE    = 6'h3F;

  // Input transaction.
  typedef struct packed {
    logic [1:0]         mode;
    logic [4:0]         source_index;
    logic signed [15:0] axis_value;
    logic               pressed;
    logic [3:0]         hat_bits;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic [5:0] port_bits;
    logic [7:0] key_row_0;
    logic [7:0] key_row_1;
    logic [7:0] key_row_2;
    logic [7:0] key_row_3;
    logic [7:0] key_row_4;
    logic [7:0] key_row_5;
    logic [7:0] key_row_6;
    logic [7:0] key_row_7;
  } out_item_t;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [1:0]       joystick_type;
    logic [14:0]      deadzone;
    logic [3:0][5:0]  dpad_button;
  } cfg_t;

  // Direction and fire requests decoded from one event.
  typedef struct packed {
    logic [3:0] dir_apply;
    logic [3:0] dir_press;
    logic [1:0] fire_apply;
    logic       fire_press;
  } dir_req_t;

  // Port bit driven by a direction in bitmask mode.
  function automatic logic [2:0] port_bit(input logic [1:0] dir);
    logic [2:0] b;
    case (dir)
      DIR_UP:    b = 3'd3;
      DIR_RIGHT: b = 3'd0;
      DIR_DOWN:  b = 3'd2;
      DIR_LEFT:  b = 3'd1;
      default:   b = 3'd0;
    endcase
    return b;
  endfunction

  // Key matrix row used by a direction in a key mode.
  function automatic logic [ROW_IDX_W-1:0] key_row(input logic [1:0] jt,
                                                    input logic [1:0] dir);
    logic [ROW_IDX_W-1:0] r;
    case (jt)
      JT_KEYS_60: r = ROW_IDX_W'(4);
      JT_KEYS_15: r = ROW_IDX_W'(3);
      JT_CURSOR: begin
        case (dir)
          DIR_UP:    r = ROW_IDX_W'(2);
          DIR_DOWN:  r = ROW_IDX_W'(1);
          default:   r = ROW_IDX_W'(5);
        endcase
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Key bit within the row used by a direction in a key mode.
  function automatic logic [2:0] key_bit(input logic [1:0] jt, input logic [1:0] dir);
    logic [2:0] b;
    case ({jt, dir})
      {JT_KEYS_60, DIR_UP}:    b = 3'd1;
      {JT_KEYS_60, DIR_RIGHT}: b = 3'd3;
      {JT_KEYS_60, DIR_DOWN}:  b = 3'd2;
      {JT_KEYS_60, DIR_LEFT}:  b = 3'd4;
      {JT_KEYS_15, DIR_UP}:    b = 3'd3;
      {JT_KEYS_15, DIR_RIGHT}: b = 3'd1;
      {JT_KEYS_15, DIR_DOWN}:  b = 3'd2;
      {JT_KEYS_15, DIR_LEFT}:  b = 3'd0;
      {JT_CURSOR, DIR_LEFT}:   b = 3'd1;
      default:                 b = 3'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/gamepad_to_joystick_port_adapter.sv =====
// Top level of the gamepad to joystick port adapter.
// Input and result registers with valid/stall handshakes around the decoder and state.
// Depends on g2j_pkg, g2j_cfg_regs, g2j_event_decode and g2j_state.
//
// Usage:
//   Input channel: in_valid, in_stall, in_data (one gamepad event per transaction).
//   Result channel: out_valid, out_stall, out_data (port bits and eight key rows).
//   Configuration: cfg_we, cfg_index, cfg_wdata; the user must write these only while
//   no event is in flight; the block does not enforce this. An accepted event lands in
//   the input register. When the output register is free it is decoded, the held flags,
//   port bits and key matrix update, and the result enters the output register and
//   out_valid rises. Throughput is one event per cycle while the receiver does not stall;
//   the whole update is one pass of compares and bit updates between the two registers.
//   When the receiver stalls, the result holds in the output register and one more
//   event may wait in the input register; after that in_stall rises.
//   Reset (rst_n low, synchronous) empties both registers, clears held flags and
//   port bits, sets every key matrix bit (no key pressed) and restores the default
//   configuration: bitmask mode, deadzone 8000, no D-pad buttons.
module gamepad_to_joystick_port_adapter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  g2j_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output g2j_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [g2j_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [g2j_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
  import g2j_pkg::*;

  logic      in_valid_r;
  logic      in_valid_nxt;
  in_item_t  in_item_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_item_r;
  logic      advance;
  logic      in_take;
  cfg_t      cfg;
  logic      port_clear;
  dir_req_t  req;
  out_item_t result_nxt;

  // Handshake control: the event moves on when the output register is free.
  always_comb begin
    advance       = in_valid_r && (!out_valid_r || !out_stall);
    in_stall      = in_valid_r && !advance;
    in_take       = in_valid && !in_stall;
    in_valid_nxt  = in_take || (in_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= result_nxt;
    end
  end

  g2j_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cfg        (cfg),
    .port_clear (port_clear)
  );

  g2j_event_decode u_decode (
    .item (in_item_r),
    .cfg  (cfg),
    .req  (req)
  );

  g2j_state u_state (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .req           (req),
    .joystick_type (cfg.joystick_type),
    .port_clear    (port_clear),
    .result_nxt    (result_nxt)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

// ===== hw/rtl/g2j_cfg_regs.sv =====
// Configuration register file of the gamepad adapter.
// Holds joystick type, deadzone and D-pad button numbers; flags a type change.
// Depends on g2j_pkg.
module g2j_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [g2j_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [g2j_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  output g2j_pkg::cfg_t                  cfg,
  output logic                           port_clear
);
  import g2j_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Register writes; a new joystick type raises port_clear for the port bits.
  always_comb begin
    cfg_nxt    = cfg_r;
    port_clear = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        CFG_JOY_TYPE: begin
          cfg_nxt.joystick_type = cfg_wdata[1:0];
          port_clear = (cfg_wdata[1:0] != cfg_r.joystick_type);
        end
        CFG_DEADZONE:   cfg_nxt.deadzone = cfg_wdata[14:0];
        CFG_DPAD_UP:    cfg_nxt.dpad_button[DIR_UP]    = cfg_wdata[5:0];
        CFG_DPAD_RIGHT: cfg_nxt.dpad_button[DIR_RIGHT] = cfg_wdata[5:0];
        CFG_DPAD_DOWN:  cfg_nxt.dpad_button[DIR_DOWN]  = cfg_wdata[5:0];
        CFG_DPAD_LEFT:  cfg_nxt.dpad_button[DIR_LEFT]  = cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.joystick_type <= JT_BITMASK;
      cfg_r.deadzone      <= DEADZONE_RST;
      cfg_r.dpad_button   <= {4{DPAD_NONE}};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/g2j_event_decode.sv =====
// Event decoder of the gamepad adapter.
// Turns one axis, button or hat event into direction and fire requests.
// Depends on g2j_pkg.
module g2j_event_decode (
  input  g2j_pkg::in_item_t  item,
  input  g2j_pkg::cfg_t      cfg,
  output g2j_pkg::dir_req_t  req
);
  import g2j_pkg::*;

  logic signed [18:0] v_x;
  logic signed [18:0] d_x;
  logic signed [18:0] two_v;
  logic signed [18:0] three_d;
  logic signed [18:0] half_d;
  logic signed [18:0] mag;
  logic [1:0]         neg_dir;
  logic [1:0]         pos_dir;
  logic               below_lo;
  logic               above_hi;
  logic               below_wide;
  logic               above_wide;
  logic               inside_half;

  // Axis thresholds, all in 19-bit signed arithmetic.
  always_comb begin
    v_x         = {{3{item.axis_value[15]}}, item.axis_value};
    d_x         = {4'b0000, cfg.deadzone};
    two_v       = v_x <<< 1;
    three_d     = d_x + (d_x <<< 1);
    half_d      = {5'b00000, cfg.deadzone[14:1]};
    mag         = v_x[18] ? -v_x : v_x;
    below_lo    = v_x < -d_x;
    above_hi    = v_x > d_x;
    below_wide  = two_v < -three_d;
    above_wide  = two_v > three_d;
    inside_half = mag < half_d;
    neg_dir     = item.source_index[0] ? DIR_UP : DIR_LEFT;
    pos_dir     = item.source_index[0] ? DIR_DOWN : DIR_RIGHT;
  end

  // Request decode per event kind.
  always_comb begin
    logic found;
    found = 1'b0;
    req   = '0;
    case (item.mode)
      EV_AXIS: begin
        if (item.source_index <= 5'd1) begin
          req.dir_apply[neg_dir] = 1'b1;
          req.dir_apply[pos_dir] = 1'b1;
          req.dir_press[neg_dir] = below_lo;
          req.dir_press[pos_dir] = above_hi;
        end else if (item.source_index <= 5'd3) begin
          if (below_wide || above_wide || inside_half) begin
            req.dir_apply[neg_dir] = 1'b1;
            req.dir_apply[pos_dir] = 1'b1;
          end
          req.dir_press[neg_dir] = below_wide;
          req.dir_press[pos_dir] = !below_wide && above_wide;
        end
      end
      EV_BUTTON: begin
        // D-pad registers are checked in order up, right, down, left.
        for (int i = 0; i < 4; i++) begin
          if (!found && ({1'b0, item.source_index} == cfg.dpad_button[i])) begin
            found            = 1'b1;
            req.dir_apply[i] = 1'b1;
            req.dir_press[i] = item.pressed;
          end
        end
        if (!found && cfg.joystick_type == JT_BITMASK && item.source_index <= 5'd1) begin
          req.fire_apply[item.source_index[0]] = 1'b1;
          req.fire_press = item.pressed;
        end
      end
      EV_HAT: begin
        if (item.source_index == 5'd0) begin
          req.dir_apply = 4'hF;
          req.dir_press = item.hat_bits;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/g2j_state.sv =====
// Held-direction flags, joystick port bits and key matrix of the adapter.
// Applies decoded requests and presents the next result transaction.
// Depends on g2j_pkg.
module g2j_state (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  g2j_pkg::dir_req_t   req,
  input  logic [1:0]          joystick_type,
  input  logic                port_clear,
  output g2j_pkg::out_item_t  result_nxt
);
  import g2j_pkg::*;

  logic [3:0]                held_r;
  logic [3:0]                held_nxt;
  logic [5:0]                port_r;
  logic [5:0]                port_nxt;
  logic [KEY_ROWS-1:0][7:0]  keys_r;
  logic [KEY_ROWS-1:0][7:0]  keys_nxt;

  // A direction acts only when its held flag changes.
  always_comb begin
    held_nxt = held_r;
    port_nxt = port_r;
    keys_nxt = keys_r;
    for (int d = 0; d < 4; d++) begin
      if (req.dir_apply[d] && (held_r[d] != req.dir_press[d])) begin
        held_nxt[d] = req.dir_press[d];
        if (joystick_type == JT_BITMASK) begin
          port_nxt[port_bit(2'(d))] = req.dir_press[d];
        end else begin
          keys_nxt[key_row(joystick_type, 2'(d))][key_bit(joystick_type, 2'(d))] =
            !req.dir_press[d];
        end
      end
    end
    for (int f = 0; f < 2; f++) begin
      if (req.fire_apply[f]) begin
        port_nxt[3'(4 + f)] = req.fire_press;
      end
    end
  end

  // State registers; a joystick type change clears the port unless an event advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      port_r <= '0;
      keys_r <= '1;
    end else if (advance) begin
      held_r <= held_nxt;
      port_r <= port_nxt;
      keys_r <= keys_nxt;
    end else if (port_clear) begin
      port_r <= '0;
    end
  end

  // Result as it stands after this event.
  always_comb begin
    result_nxt.port_bits = port_nxt;
    result_nxt.key_row_0 = keys_nxt[0];
    result_nxt.key_row_1 = keys_nxt[1];
    result_nxt.key_row_2 = keys_nxt[2];
    result_nxt.key_row_3 = keys_nxt[3];
    result_nxt.key_row_4 = keys_nxt[4];
    result_nxt.key_row_5 = keys_nxt[5];
    result_nxt.key_row_6 = keys_nxt[6];
    result_nxt.key_row_7 = keys_nxt[7];
  end

  // A type change while no event advances leaves the port clear.
  a_port_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    port_clear && !advance |=> port_r == 6'd0)
    else $error("port bits not cleared after joystick type change");

  // Bitmask mode never touches the key matrix.
  a_keys_bitmask: assert property (@(posedge clk) disable iff (!rst_n)
    advance && joystick_type == JT_BITMASK |=> $stable(keys_r))
    else $error("key matrix changed in bitmask mode");

  // Key modes never touch the port bits.
  a_port_keymode: assert property (@(posedge clk) disable iff (!rst_n)
    advance && joystick_type != JT_BITMASK && !port_clear |=> $stable(port_r))
    else $error("port bits changed in a key mode");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the gamepad to joystick port adapter.
// Directed and random gamepad events are checked against a predictor of the port and key matrix.
// Depends on g2j_pkg and gamepad_to_joystick_port_adapter.
`timescale 1ns / 100ps

module tb;
  import g2j_pkg::*;

  // Event kind that the block treats as a no-op.
  localparam logic [1:0] EV_UNUSED = 2'd3;
  // Fire buttons in bitmask mode.
  localparam logic [2:0] FIRE_BIT  = 3'd4;
  localparam logic [2:0] FIRE2_BIT = 3'd5;
  // Cycles let pass once the last result is in (two register stages plus margin).
  localparam int unsigned SETTLE_CYCLES = 4;
  // Events between two reconfigurations in the random part.
  localparam int unsigned EVENTS_PER_SETTING = 60;
  localparam int unsigned TIMEOUT_NS = 12 * 300000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  // Mirror of the block's configuration and state.
  logic [1:0]         joy_type;
  logic [14:0]        dz_val;
  logic signed [5:0]  dpad_map [4];
  logic [3:0]         held_dirs;
  logic [5:0]         port_img;
  logic [7:0]         key_img [KEY_ROWS];

  out_item_t   pending_ports_q [$];
  int unsigned fail_cnt    = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  gamepad_to_joystick_port_adapter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial forever #6 clk = ~clk;

  // The run ends here if the block stops answering.
  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  // Port bit that a direction drives in bitmask mode.
  function automatic logic [2:0] port_pos(input logic [1:0] dir);
    case (dir)
      DIR_UP:    return 3'd3;
      DIR_RIGHT: return 3'd0;
      DIR_DOWN:  return 3'd2;
      default:   return 3'd1;
    endcase
  endfunction

  // Key position {row, bit} that a direction uses in a key mode.
  function automatic logic [5:0] key_slot(input logic [1:0] jt, input logic [1:0] dir);
    case ({jt, dir})
      {JT_KEYS_60, DIR_UP}:    return {3'd4, 3'd1};
      {JT_KEYS_60, DIR_RIGHT}: return {3'd4, 3'd3};
      {JT_KEYS_60, DIR_DOWN}:  return {3'd4, 3'd2};
      {JT_KEYS_60, DIR_LEFT}:  return {3'd4, 3'd4};
      {JT_KEYS_15, DIR_UP}:    return {3'd3, 3'd3};
      {JT_KEYS_15, DIR_RIGHT}: return {3'd3, 3'd1};
      {JT_KEYS_15, DIR_DOWN}:  return {3'd3, 3'd2};
      {JT_KEYS_15, DIR_LEFT}:  return {3'd3, 3'd0};
      {JT_CURSOR, DIR_UP}:     return {3'd2, 3'd0};
      {JT_CURSOR, DIR_RIGHT}:  return {3'd5, 3'd0};
      {JT_CURSOR, DIR_DOWN}:   return {3'd1, 3'd0};
      default:                 return {3'd5, 3'd1};
    endcase
  endfunction

  // A direction acts only when its held flag changes.
  function automatic void set_direction(input logic [1:0] dir, input logic press);
    logic [5:0] slot;
    if (held_dirs[dir] == press) return;
    held_dirs[dir] = press;
    if (joy_type == JT_BITMASK) begin
      port_img[port_pos(dir)] = press;
    end else begin
      slot = key_slot(joy_type, dir);
      key_img[slot[5:3]][slot[2:0]] = ~press;
    end
  endfunction

  // Axes 0 and 1 use a plain threshold, axes 2 and 3 a band with hysteresis.
  function automatic void axis_move(input logic [4:0] axis, input logic signed [15:0] raw);
    int v;
    int d;
    int mag;
    logic [1:0] neg;
    logic [1:0] pos;
    v   = int'(raw);
    d   = int'(dz_val);
    mag = (v < 0) ? -v : v;
    neg = axis[0] ? DIR_UP : DIR_LEFT;
    pos = axis[0] ? DIR_DOWN : DIR_RIGHT;
    if (axis <= 1) begin
      if (v < -d) begin
        set_direction(neg, 1'b1);
        set_direction(pos, 1'b0);
      end else if (v > d) begin
        set_direction(pos, 1'b1);
        set_direction(neg, 1'b0);
      end else begin
        set_direction(neg, 1'b0);
        set_direction(pos, 1'b0);
      end
    end else if (axis <= 3) begin
      if (2 * v < -3 * d) begin
        set_direction(neg, 1'b1);
        set_direction(pos, 1'b0);
      end else if (2 * v > 3 * d) begin
        set_direction(pos, 1'b1);
        set_direction(neg, 1'b0);
      end else if (mag < d / 2) begin
        set_direction(neg, 1'b0);
        set_direction(pos, 1'b0);
      end
    end
  endfunction

  // D-pad buttons win over the fire buttons; they are matched up, right, down, left.
  function automatic void button_change(input logic [4:0] btn, input logic press);
    int sel;
    for (int i = 0; i < 4; i++) begin
      sel = int'(dpad_map[i]);
      if (int'(btn) == sel) begin
        set_direction(2'(i), press);
        return;
      end
    end
    if (joy_type == JT_BITMASK && btn <= 1)
      port_img[btn[0] ? FIRE2_BIT : FIRE_BIT] = press;
  endfunction

  // Applies one event to the mirror and returns the result it should produce.
  function automatic out_item_t predict_ports(input in_item_t ev);
    out_item_t r;
    case (ev.mode)
      EV_AXIS:   axis_move(ev.source_index, ev.axis_value);
      EV_BUTTON: button_change(ev.source_index, ev.pressed);
      EV_HAT: begin
        if (ev.source_index == 0) begin
          set_direction(DIR_UP, ev.hat_bits[DIR_UP]);
          set_direction(DIR_DOWN, ev.hat_bits[DIR_DOWN]);
          set_direction(DIR_LEFT, ev.hat_bits[DIR_LEFT]);
          set_direction(DIR_RIGHT, ev.hat_bits[DIR_RIGHT]);
        end
      end
      default: ;
    endcase
    r.port_bits = port_img;
    r.key_row_0 = key_img[0];
    r.key_row_1 = key_img[1];
    r.key_row_2 = key_img[2];
    r.key_row_3 = key_img[3];
    r.key_row_4 = key_img[4];
    r.key_row_5 = key_img[5];
    r.key_row_6 = key_img[6];
    r.key_row_7 = key_img[7];
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // The receiver stalls at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Each result transaction is compared with the oldest prediction.
  always @(posedge clk) begin : result_check
    out_item_t           want;
    logic [8*KEY_ROWS-1:0] want_rows;
    logic [8*KEY_ROWS-1:0] got_rows;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ports_q.size() == 0) begin
        $error("unexpected result: port_bits %0h", out_data.port_bits);
        fail_cnt++;
      end else begin
        want      = pending_ports_q.pop_front();
        want_rows = want[8*KEY_ROWS-1:0];
        got_rows  = out_data[8*KEY_ROWS-1:0];
        if (out_data.port_bits !== want.port_bits) begin
          $error("port_bits: expected %0h, actual %0h", want.port_bits, out_data.port_bits);
          fail_cnt++;
        end
        for (int r = 0; r < KEY_ROWS; r++) begin
          if (got_rows[8*(KEY_ROWS-1-r) +: 8] !== want_rows[8*(KEY_ROWS-1-r) +: 8]) begin
            $error("key_row_%0d: expected %0h, actual %0h", r,
                   want_rows[8*(KEY_ROWS-1-r) +: 8], got_rows[8*(KEY_ROWS-1-r) +: 8]);
            fail_cnt++;
          end
        end
      end
    end
  end

  function automatic in_item_t gamepad_event(input logic [1:0] mode, input int src,
                                             input int value, input logic press,
                                             input logic [3:0] hat);
    in_item_t ev;
    ev.mode         = mode;
    ev.source_index = 5'(src);
    ev.axis_value   = 16'(value);
    ev.pressed      = press;
    ev.hat_bits     = hat;
    return ev;
  endfunction

  // Sends one input transaction and records its prediction once it is accepted.
  task automatic send_event(input in_item_t ev);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_ports_q.push_back(predict_ports(ev));
  endtask

  // Waits until every predicted result has arrived and the block is idle.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_ports_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_JOY_TYPE: begin
        // A new mode clears the port; held flags and keys stay.
        if (data[1:0] != joy_type) begin
          joy_type = data[1:0];
          port_img = '0;
        end
      end
      CFG_DEADZONE: dz_val = data;
      CFG_DPAD_UP, CFG_DPAD_RIGHT, CFG_DPAD_DOWN, CFG_DPAD_LEFT:
        dpad_map[2'(idx - CFG_DPAD_UP)] = data[5:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Writes all six registers once the block is idle; unused upper bits are random.
  task automatic apply_config(input logic [1:0] jt, input int dz, input int up, input int right,
                              input int down, input int left);
    logic [CFG_DAT_W-1:0] data;
    wait_results_done();
    data = CFG_DAT_W'($urandom);
    data[1:0] = jt;
    write_reg(CFG_JOY_TYPE, data);
    write_reg(CFG_DEADZONE, CFG_DAT_W'(dz));
    data = CFG_DAT_W'($urandom);
    data[5:0] = 6'(up);
    write_reg(CFG_DPAD_UP, data);
    data = CFG_DAT_W'($urandom);
    data[5:0] = 6'(right);
    write_reg(CFG_DPAD_RIGHT, data);
    data = CFG_DAT_W'($urandom);
    data[5:0] = 6'(down);
    write_reg(CFG_DPAD_DOWN, data);
    data = CFG_DAT_W'($urandom);
    data[5:0] = 6'(left);
    write_reg(CFG_DPAD_LEFT, data);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    send_event(gamepad_event(EV_UNUSED, 31, 32767, 1'b1, 4'hF));
  endtask

  task automatic test_primary_axes();
    send_event(gamepad_event(EV_AXIS, 0, -32768, 1'b0, 4'h0));
    send_event(gamepad_event(EV_AXIS, 0, 32767, 1'b1, 4'hF));
    send_event(gamepad_event(EV_AXIS, 0, 8000, 1'b0, 4'h0));
    send_event(gamepad_event(EV_AXIS, 1, -8001, 1'b1, 4'h5));
  endtask

  // Trigger axes press beyond 3/2 of the deadzone and release under half of it.
  task automatic test_trigger_axes();
    send_event(gamepad_event(EV_AXIS, 2, 12000, 1'b0, 4'h0));
    send_event(gamepad_event(EV_AXIS, 2, 12001, 1'b0, 4'h0));
    send_event(gamepad_event(EV_AXIS, 2, 4000, 1'b0, 4'h0));
    send_event(gamepad_event(EV_AXIS, 2, 3999, 1'b0, 4'h0));
    send_event(gamepad_event(EV_AXIS, 9, -32768, 1'b1, 4'hA));
  endtask

  task automatic test_hat();
    send_event(gamepad_event(EV_HAT, 0, 0, 1'b0, 4'hF));
    send_event(gamepad_event(EV_HAT, 7, 0, 1'b0, 4'h0));
    send_event(gamepad_event(EV_HAT, 0, -1, 1'b1, 4'h0));
  endtask

  task automatic test_fire_buttons();
    send_event(gamepad_event(EV_BUTTON, 0, 0, 1'b1, 4'h0));
    send_event(gamepad_event(EV_BUTTON, 1, 0, 1'b1, 4'h0));
    send_event(gamepad_event(EV_BUTTON, 1, 0, 1'b0, 4'h0));
  endtask

  // Button 0 mapped as D-pad right no longer acts as fire.
  task automatic test_dpad_buttons();
    apply_config(JT_BITMASK, int'(DEADZONE_RST), 31, 0, 5, -1);
    send_event(gamepad_event(EV_BUTTON, 0, 0, 1'b1, 4'h0));
    send_event(gamepad_event(EV_BUTTON, 31, 0, 1'b1, 4'h0));
  endtask

  // Every key mode, and a mode change that clears the port.
  task automatic test_key_modes();
    apply_config(JT_CURSOR, int'(DEADZONE_RST), 31, 0, 5, -1);
    send_event(gamepad_event(EV_HAT, 0, 0, 1'b0, 4'hF));
    apply_config(JT_KEYS_60, int'(DEADZONE_RST), 31, 0, 5, -1);
    send_event(gamepad_event(EV_HAT, 0, 0, 1'b0, 4'h0));
    apply_config(JT_KEYS_15, int'(DEADZONE_RST), 31, 0, 5, -1);
    send_event(gamepad_event(EV_HAT, 0, 0, 1'b0, 4'hF));
    apply_config(JT_BITMASK, int'(DEADZONE_RST), 31, 0, 5, -1);
    send_event(gamepad_event(EV_HAT, 0, 0, 1'b0, 4'h0));
  endtask

  task automatic test_deadzone_extremes();
    apply_config(JT_BITMASK, 0, -1, -1, -1, -1);
    send_event(gamepad_event(EV_AXIS, 0, 1, 1'b0, 4'h0));
    apply_config(JT_BITMASK, 32767, -1, -1, -1, -1);
    send_event(gamepad_event(EV_AXIS, 3, -32768, 1'b0, 4'h0));
    send_event(gamepad_event(EV_AXIS, 1, -32768, 1'b0, 4'h0));
  endtask

  task automatic random_config();
    int dz;
    int btn [4];
    case ($urandom_range(0, 5))
      0:       dz = 0;
      1:       dz = 32767;
      2:       dz = int'(DEADZONE_RST);
      3:       dz = $urandom_range(0, 3000);
      default: dz = $urandom_range(0, 32767);
    endcase
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(0, 2) == 0) btn[i] = -1;
      else if ($urandom_range(0, 3) == 0) btn[i] = $urandom_range(0, 31);
      else btn[i] = $urandom_range(0, 5);
    end
    apply_config(2'($urandom_range(0, 3)), dz, btn[0], btn[1], btn[2], btn[3]);
  endtask

  // Mostly meaningful events, axis values clustered around the thresholds.
  function automatic in_item_t random_event();
    in_item_t ev;
    int d;
    int v;
    int sel;
    d  = int'(dz_val);
    ev = gamepad_event(EV_UNUSED, $urandom_range(0, 31), $urandom,
                       1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      ev.mode = EV_AXIS;
      if ($urandom_range(0, 99) < 85) ev.source_index = 5'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
        0:       v = d + $urandom_range(0, 1);
        1:       v = (3 * d) / 2 + $urandom_range(0, 2) - 1;
        2:       v = d / 2 - $urandom_range(0, 1);
        3:       v = $urandom_range(0, 1) ? 32767 : -32768;
        4:       v = $urandom_range(0, 200) - 100;
        default: v = $urandom_range(0, 65535) - 32768;
      endcase
      if (v <= 32767 && $urandom_range(0, 1)) v = -v;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      ev.axis_value = 16'(v);
    end else if (sel < 70) begin
      ev.mode = EV_BUTTON;
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        v = int'(dpad_map[2'($urandom_range(0, 3))]);
        ev.source_index = (v >= 0) ? 5'(v) : 5'($urandom_range(0, 3));
      end else if (sel < 70) begin
        ev.source_index = 5'($urandom_range(0, 1));
      end
    end else if (sel < 95) begin
      ev.mode = EV_HAT;
      if ($urandom_range(0, 99) < 85) ev.source_index = 5'd0;
    end
    return ev;
  endfunction

  task automatic test_random_traffic(input int unsigned count, input int unsigned tx_pct,
                                     input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % EVENTS_PER_SETTING == 0) random_config();
      send_event(random_event());
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    joy_type  = JT_BITMASK;
    dz_val    = DEADZONE_RST;
    held_dirs = '0;
    port_img  = '0;
    for (int i = 0; i < 4; i++) dpad_map[i] = DPAD_NONE;
    for (int r = 0; r < KEY_ROWS; r++) key_img[r] = 8'hFF;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 35;
    rx_idle_pct = 61;
    test_reset_state();
    test_primary_axes();
    test_trigger_axes();
    test_hat();
    test_fire_buttons();
    test_dpad_buttons();
    test_key_modes();
    test_deadzone_extremes();

    test_random_traffic(400, 35, 61);
    test_random_traffic(400, 61, 35);
    test_random_traffic(400, 0, 0);

    wait_results_done();
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
